/* hw/rtl/smps_pkg.sv */
// Shared types and constants for the stepper move/pause sequencer.
// No dependencies; compile first.
package smps_pkg;

  localparam int unsigned MoveW   = 10;
  localparam int unsigned IntW    = 14;
  localparam int unsigned PauseW  = 16;
  localparam int unsigned WaitW   = 16;
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;

  localparam logic [MoveW-1:0]  MoveRst  = 10'd100;
  localparam logic [MoveW-1:0]  RampRst  = 10'd20;
  localparam logic [IntW-1:0]   IntRst   = 14'd20;
  localparam logic [PauseW-1:0] PauseRst = 16'd2000;

  // register index, byte address is 4x this
  typedef enum logic [2:0] {
    REG_MOVE  = 3'd0,
    REG_RAMP  = 3'd1,
    REG_INT   = 3'd2,
    REG_PAUSE = 3'd3,
    REG_DIR   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [MoveW-1:0]  move_steps;
    logic [MoveW-1:0]  ramp_steps;
    logic [IntW-1:0]   step_interval_ms;
    logic [PauseW-1:0] pause_ms;
    logic              direction;
  } cfg_t;

  typedef struct packed {
    logic             step_pulse;
    logic             dir_level;
    logic             in_pause;
    logic [MoveW-1:0] steps_done;
  } res_t;

endpackage

/* hw/rtl/smps_in_if.sv */
// Input channel: one word per millisecond tick slot.
// Depends on nothing.
interface smps_in_if;
  logic valid;
  logic ready;
  logic ms_tick;

  modport source (output valid, output ms_tick, input ready);
  modport sink   (input valid, input ms_tick, output ready);
endinterface

/* hw/rtl/smps_out_if.sv */
// Result channel: step pulse, direction, phase and step count.
// Depends on nothing.
interface smps_out_if;
  logic       valid;
  logic       ready;
  logic       step_pulse;
  logic       dir_level;
  logic       in_pause;
  logic [9:0] steps_done;

  modport source (output valid, output step_pulse, output dir_level,
                  output in_pause, output steps_done, input ready);
  modport sink   (input valid, input step_pulse, input dir_level,
                  input in_pause, input steps_done, output ready);
endinterface

/* hw/rtl/stepper_move_pause_sequencer.sv */
// Top level of the stepper move/pause sequencer: input register, state update,
// result register and settings port. Depends on smps_pkg, smps_in_if,
// smps_out_if, smps_cfg and smps_core.
//
//   channel   direction  handshake             word
//   in_chan   in         valid/ready           ms_tick
//   out_chan  out        valid/ready           step_pulse, dir_level, in_pause, steps_done
//   cfg       in         psel/penable, pready  5 registers at byte address 4*i
//
// One word in, one word out; a new word is taken every cycle unless the
// result stalls. A word passes the input register, then the state update
// feeding the result register. The state update is one compare, decrement and reload.
// rst_n is synchronous: state clears to rotate phase, count zero, step on the
// first tick, and the settings return to their defaults.
// A stalled result holds the result register; the input register then holds
// too, and in_chan.ready drops once both are full.
module stepper_move_pause_sequencer (
  input  logic                        clk,
  input  logic                        rst_n,
  smps_in_if.sink                     in_chan,
  smps_out_if.source                  out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [smps_pkg::AddrW-1:0]  paddr,
  input  logic [smps_pkg::DataW-1:0]  pwdata,
  output logic [smps_pkg::DataW-1:0]  prdata,
  output logic                        pready
);
  import smps_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_r;

  logic s1_valid_r, s1_valid_nxt;
  logic s1_tick_r;
  logic out_valid_r, out_valid_nxt;
  logic s1_adv;
  logic in_acc;

  smps_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  smps_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (s1_adv),
    .tick  (s1_tick_r),
    .cfg   (cfg),
    .res   (res)
  );

  // advance the input word whenever the result register is free or draining
  assign s1_adv        = s1_valid_r & (~out_valid_r | out_chan.ready);
  assign in_chan.ready = ~s1_valid_r | s1_adv;
  assign in_acc        = in_chan.valid & in_chan.ready;

  assign s1_valid_nxt  = in_acc | (s1_valid_r & ~s1_adv);
  assign out_valid_nxt = s1_adv | (out_valid_r & ~out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers: load on capture, hold otherwise
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_tick_r <= in_chan.ms_tick;
    end
    if (s1_adv) begin
      res_r <= res;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.step_pulse = res_r.step_pulse;
  assign out_chan.dir_level  = res_r.dir_level;
  assign out_chan.in_pause   = res_r.in_pause;
  assign out_chan.steps_done = res_r.steps_done;

  // a word moved out of the input register lands in the result register
  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("advanced word did not reach the result register");

  // direction is held low throughout the pause
  a_pause_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.in_pause) |-> !res_r.dir_level)
    else $error("direction driven during pause");

  // a step pulse always leaves a non-zero count
  a_pulse_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.step_pulse) |-> (res_r.steps_done != '0))
    else $error("step pulse with zero count");
endmodule

/* hw/rtl/smps_cfg.sv */
// APB-style register file for the sequencer settings.
// Depends on smps_pkg.
module smps_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [smps_pkg::AddrW-1:0]  paddr,
  input  logic [smps_pkg::DataW-1:0]  pwdata,
  output logic [smps_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  output smps_pkg::cfg_t              cfg
);
  import smps_pkg::*;

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[AddrW-1:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.move_steps       <= MoveRst;
      cfg_r.ramp_steps       <= RampRst;
      cfg_r.step_interval_ms <= IntRst;
      cfg_r.pause_ms         <= PauseRst;
      cfg_r.direction        <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_MOVE:  cfg_r.move_steps       <= pwdata[MoveW-1:0];
        REG_RAMP:  cfg_r.ramp_steps       <= pwdata[MoveW-1:0];
        REG_INT:   cfg_r.step_interval_ms <= pwdata[IntW-1:0];
        REG_PAUSE: cfg_r.pause_ms         <= pwdata[PauseW-1:0];
        REG_DIR:   cfg_r.direction        <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MOVE:  prdata = {{(DataW-MoveW){1'b0}}, cfg_r.move_steps};
      REG_RAMP:  prdata = {{(DataW-MoveW){1'b0}}, cfg_r.ramp_steps};
      REG_INT:   prdata = {{(DataW-IntW){1'b0}}, cfg_r.step_interval_ms};
      REG_PAUSE: prdata = {{(DataW-PauseW){1'b0}}, cfg_r.pause_ms};
      REG_DIR:   prdata = {{(DataW-1){1'b0}}, cfg_r.direction};
      default:   prdata = '0;
    endcase
  end
endmodule

/* hw/rtl/smps_core.sv */
// Sequencer state (phase, countdown, step count) and its per-word update.
// Depends on smps_pkg.
module smps_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           tick,
  input  smps_pkg::cfg_t cfg,
  output smps_pkg::res_t res
);
  import smps_pkg::*;

  logic              phase_r, phase_nxt;
  logic [WaitW-1:0]  wait_r, wait_nxt;
  logic [MoveW-1:0]  count_r, count_nxt;

  logic              pulse;
  logic [MoveW-1:0]  count_inc;
  logic [WaitW-1:0]  base;
  logic [WaitW-1:0]  gap_m1;
  logic              slow;

  always_comb begin
    count_inc = count_r + 1'b1;
    // zero interval behaves as one tick
    base = (cfg.step_interval_ms == '0) ? WaitW'(1)
                                         : WaitW'(cfg.step_interval_ms);
    slow = (count_inc < cfg.ramp_steps) ||
           ((cfg.ramp_steps <= cfg.move_steps) &&
            (count_inc > (cfg.move_steps - cfg.ramp_steps)));
    // slow rate is three times the base gap
    gap_m1 = slow ? ((base << 1) + base - 1'b1) : (base - 1'b1);

    phase_nxt = phase_r;
    wait_nxt  = wait_r;
    count_nxt = count_r;
    pulse     = 1'b0;
    if (tick) begin
      priority if (wait_r != '0) begin
        wait_nxt = wait_r - 1'b1;
      end else if (!phase_r) begin
        pulse     = 1'b1;
        count_nxt = count_inc;
        wait_nxt  = gap_m1;
        if (count_inc >= cfg.move_steps) begin
          phase_nxt = 1'b1;
          wait_nxt  = (cfg.pause_ms == '0) ? '0 : cfg.pause_ms - 1'b1;
        end
      end else begin
        // pause over: restart the move
        phase_nxt = 1'b0;
        count_nxt = '0;
        wait_nxt  = '0;
      end
    end

    res.step_pulse = pulse;
    res.dir_level  = phase_nxt ? 1'b0 : cfg.direction;
    res.in_pause   = phase_nxt;
    res.steps_done = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
      wait_r  <= '0;
      count_r <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      wait_r  <= wait_nxt;
      count_r <= count_nxt;
    end
  end
endmodule
